/* src/mvf_pkg.sv */
// ----------------------------------------------------------------------------
// mvf_pkg
// shared constants, types and helpers of the max value frequency block
// ----------------------------------------------------------------------------
package mvf_pkg;

  localparam int unsigned VALUE_BITS = 10;
  localparam int unsigned MAX_ITEMS  = 65536;

  localparam int unsigned IN_W     = 10;
  localparam int unsigned OUT_W    = 17;
  localparam int unsigned IN_BYTES = (IN_W + 7) / 8;
  localparam int unsigned OUT_BYTES = (OUT_W + 7) / 8;
  localparam int unsigned IDX_W    = VALUE_BITS;
  localparam int unsigned DEPTH    = 1 << IDX_W;
  localparam int unsigned CNT_W    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned EPOCH_W  = 8;
  localparam int unsigned ENTRY_W  = EPOCH_W + CNT_W;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  typedef struct packed {
    epoch_t tag;
    cnt_t   cnt;
  } entry_t;

  typedef struct packed {
    logic active;
    idx_t addr;
  } sweep_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } sweep_state_e;

  function automatic idx_t table_index(logic signed [IN_W-1:0] v);
    logic signed [31:0] ext;
    ext = 32'(v);
    return ext[IDX_W-1:0];
  endfunction

endpackage

/* src/mvf_ram.sv */
// ----------------------------------------------------------------------------
// mvf_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mvf_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* src/mvf_sweep.sv */
// ----------------------------------------------------------------------------
// mvf_sweep
// clearing pass over the histogram after reset and on epoch wrap
// ----------------------------------------------------------------------------
module mvf_sweep (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output mvf_pkg::sweep_t sweep_o
);
  import mvf_pkg::*;

  sweep_state_e state_q, state_d;
  idx_t         addr_q, addr_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (addr_q == idx_t'(DEPTH - 1)) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (start_i) begin
          state_d = ST_CLEAR;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    addr_d         = addr_q;
    sweep_o.active = 1'b0;
    sweep_o.addr   = addr_q;
    unique case (state_q)
      ST_CLEAR: begin
        sweep_o.active = 1'b1;
        addr_d         = addr_q + idx_t'(1);
      end
      ST_RUN: begin
        addr_d = '0;
      end
      default: addr_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      addr_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
    end
  end

endmodule

/* src/max_value_frequency_top.sv */
// ----------------------------------------------------------------------------
// max_value_frequency_top
// largest occurrence count of any value in a streamed data set
// ----------------------------------------------------------------------------
// Values arrive one per beat, tlast on the final one of a set. Each beat does a
// read-modify-write of one histogram entry in a 1024 x 25 ram, with a registered
// read and forwarding, so one beat is taken every cycle unless a clearing pass is
// due or running or a tlast beat waits on a full output; the largest count of
// the set leaves as one output beat after the tlast beat, held in an output
// register. Each entry carries an 8-bit set tag, so clearing between sets is free;
// after reset and once every 256 sets a clearing pass runs, s_axis_tready_o low.
module max_value_frequency_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [mvf_pkg::IN_BYTES*8-1:0]  s_axis_tdata_i,  // [9:0] value
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [mvf_pkg::OUT_BYTES*8-1:0] m_axis_tdata_o   // [16:0] max_count
);
  import mvf_pkg::*;

  sweep_t sweep;
  logic   in_acc;
  logic   wrap_req;

  logic   s1_valid_q;
  logic   s1_last_q;
  idx_t   s1_idx_q;
  logic   s1_go;

  epoch_t epoch_q;
  cnt_t   run_q;
  logic   fwd_valid_q;
  idx_t   fwd_idx_q;
  cnt_t   fwd_cnt_q;

  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;

  entry_t rd_entry;
  entry_t wr_entry;
  logic   we;
  idx_t   waddr;
  cnt_t   base;
  cnt_t   cnt_new;
  cnt_t   max_new;

  assign s1_go    = s1_valid_q && (!s1_last_q || !out_valid_q || m_axis_tready_i);
  assign wrap_req = s1_go && s1_last_q && (epoch_q == '1);

  assign s_axis_tready_o = !sweep.active && !(s1_valid_q && s1_last_q && (epoch_q == '1))
                           && (!s1_valid_q || s1_go);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  mvf_sweep u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wrap_req),
    .sweep_o (sweep)
  );

  // read-modify-write of the entry
  always_comb begin
    if (fwd_valid_q && (fwd_idx_q == s1_idx_q)) begin
      base = fwd_cnt_q;
    end else if (rd_entry.tag == epoch_q) begin
      base = rd_entry.cnt;
    end else begin
      base = '0;
    end
    cnt_new = (base < cnt_t'(MAX_ITEMS)) ? base + cnt_t'(1) : base;
    max_new = (cnt_new > run_q) ? cnt_new : run_q;
  end

  always_comb begin
    if (sweep.active) begin
      we           = 1'b1;
      waddr        = sweep.addr;
      wr_entry.tag = '0;
      wr_entry.cnt = '0;
    end else begin
      we           = s1_go;
      waddr        = s1_idx_q;
      wr_entry.tag = epoch_q;
      wr_entry.cnt = cnt_new;
    end
  end

  mvf_ram #(
    .DATA_W (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wr_entry),
    .re_i    (in_acc),
    .raddr_i (table_index(s_axis_tdata_i[IN_W-1:0])),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      epoch_q     <= '0;
      run_q       <= '0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        fwd_valid_q <= !s1_last_q;
        if (s1_last_q) begin
          run_q   <= '0;
          epoch_q <= epoch_q + epoch_t'(1);
        end else begin
          run_q <= max_new;
        end
      end
      if (s1_go && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q  <= table_index(s_axis_tdata_i[IN_W-1:0]);
      s1_last_q <= s_axis_tlast_i;
    end
    if (s1_go) begin
      fwd_idx_q <= s1_idx_q;
      fwd_cnt_q <= cnt_new;
    end
    if (s1_go && s1_last_q) begin
      out_data_q <= OUT_W'(max_new);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = (OUT_BYTES*8)'(out_data_q);

  a_no_accept_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep.active |-> !s_axis_tready_o) else $error("beat accepted during clearing pass");

  a_set_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_last_q) |=> (run_q == '0) && !fwd_valid_q)
    else $error("running max or forward path not cleared at end of set");

  a_max_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && !s1_last_q) |=> (run_q >= $past(cnt_new)))
    else $error("running max below a written count");

endmodule

/* bench/max_value_frequency_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_value_frequency_top_tb
// self-checking bench for the max value frequency block
// ----------------------------------------------------------------------------
// Value sets are streamed in with random bursts and gaps while the output side
// stalls on its own pattern. Every accepted beat updates a local histogram, and
// each tlast beat queues the largest count of its set, which is compared with
// the next output beat. The stimulus covers field extremes, back-to-back
// repeats of one value, a long output stall that backs up the input, and
// enough sets to wrap the set tag and trigger a clearing pass.
// ----------------------------------------------------------------------------
module max_value_frequency_top_tb;

  import mvf_pkg::*;

  typedef logic [IN_W-1:0]  value_t;
  typedef logic [OUT_W-1:0] count_t;

  typedef enum int {
    MIX_SPREAD,
    MIX_HOT_POOL,
    MIX_EXTREMES
  } value_mix_e;

  class mode_count_board;
    int unsigned occurrences[DEPTH];
    int unsigned top_count;
    count_t      expected_max_counts[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      start_new_set();
    endfunction

    function void start_new_set();
      foreach (occurrences[i]) occurrences[i] = 0;
      top_count = 0;
    endfunction

    function void note_beat(value_t raw, bit last);
      logic signed [31:0] wide;
      int unsigned        slot;
      wide = 32'($signed(raw));
      slot = int'(wide[VALUE_BITS-1:0]);
      if (occurrences[slot] < MAX_ITEMS) occurrences[slot]++;
      if (occurrences[slot] > top_count) top_count = occurrences[slot];
      if (last) begin
        expected_max_counts.push_back(count_t'(top_count));
        start_new_set();
      end
    endfunction

    function void check_result(count_t got);
      count_t want;
      if (expected_max_counts.size() == 0) begin
        $display("%0t: max_count got %0d with none expected", $time, got);
        mismatches++;
      end else begin
        want = expected_max_counts.pop_front();
        if (got !== want) begin
          $display("%0t: max_count expected %0d, got %0d", $time, want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_BYTES*8-1:0] s_axis_tdata_i;   // [9:0] value
  logic                  s_axis_tlast_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_BYTES*8-1:0] m_axis_tdata_o;  // [16:0] max_count

  mode_count_board board;
  int  burst_left = 0;
  bit  steady = 0;
  bit  hold_request = 0;
  value_t set_values[$];

  max_value_frequency_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

  // output side: random ready pattern, plus one long hold on request
  initial begin
    int run_left;
    int hold_left;
    bit ready_now;
    run_left  = 0;
    hold_left = 0;
    ready_now = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (run_left == 0) begin
          case ($urandom_range(0, 5))
            0, 1: begin
              ready_now = 1'b1;
              run_left = $urandom_range(1, 20);
            end
            2: begin
              ready_now = 1'b1;
              run_left = $urandom_range(30, 60);
            end
            default: begin
              ready_now = 1'b0;
              run_left = $urandom_range(1, 8);
            end
          endcase
        end
        run_left--;
        m_axis_tready_i <= ready_now;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_result(m_axis_tdata_o[OUT_W-1:0]);
    end
  end

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_beat(input value_t v, input bit last);
    logic [IN_BYTES*8-1:0] word;
    int gap;
    word = '0;
    word[IN_W-1:0] = v;
    if (!steady && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_beat(v, last);
  endtask

  task automatic send_listed_set();
    foreach (set_values[i]) send_beat(set_values[i], i == set_values.size() - 1);
    set_values.delete();
  endtask

  task automatic send_random_set(input int len);
    value_mix_e mix;
    value_t     pool[4];
    value_t     v;
    mix = value_mix_e'($urandom_range(0, 2));
    foreach (pool[p]) pool[p] = value_t'($urandom);
    for (int k = 0; k < len; k++) begin
      case (mix)
        MIX_SPREAD:   v = value_t'($urandom);
        MIX_HOT_POOL: v = pool[$urandom_range(0, 3)];
        default: begin
          case ($urandom_range(0, 3))
            0:       v = value_t'(-512);
            1:       v = value_t'(511);
            2:       v = '0;
            default: v = '1;
          endcase
        end
      endcase
      send_beat(v, k == len - 1);
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (board.expected_max_counts.size() != 0);
  endtask

  initial begin
    int sent;
    int len;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    rst_ni          <= 1'b0;
    board = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-beat sets at the extremes, then one value repeated
    set_values = '{value_t'(-512)};
    send_listed_set();
    set_values = '{value_t'(511)};
    send_listed_set();
    set_values = '{value_t'(0), value_t'(0), value_t'(0)};
    send_listed_set();
    // -1, 511 and -512 must land in different entries
    set_values = '{value_t'(-1), value_t'(511), value_t'(-1), value_t'(-512), value_t'(-1)};
    send_listed_set();
    // the maximum is reached on the tlast beat itself
    set_values = '{value_t'(7), value_t'(3), value_t'(3), value_t'(7), value_t'(7)};
    send_listed_set();
    set_values = '{value_t'(341), value_t'(-342), value_t'(341), value_t'(-342)};
    send_listed_set();
    drain();

    // repeated value and random sets, back to back
    steady = 1;
    for (int k = 0; k < 24; k++) send_beat(value_t'(-300), k == 23);
    repeat (4) send_random_set($urandom_range(4, 24));
    steady = 0;
    drain();

    // long output hold while short sets keep coming
    hold_request = 1;
    repeat (40) send_random_set($urandom_range(1, 3));
    drain();

    sent = 0;
    while (sent < 200) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = $urandom_range(1, 3);
        4, 5, 6, 7: len = $urandom_range(4, 24);
        8:          len = $urandom_range(25, 80);
        default:    len = 1;
      endcase
      send_random_set(len);
      sent += len;
      if ($urandom_range(0, 15) == 0) drain();
    end

    // enough short sets to wrap the set tag
    repeat (210) send_random_set($urandom_range(1, 2));
    drain();
    repeat (16) @(posedge clk_i);

    if (board.mismatches == 0 && board.expected_max_counts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
